/* sv/mlalu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlalu_pkg
// shared types and constants for the limb-serial multiword alu
// ----------------------------------------------------------------------------
package mlalu_pkg;

  localparam int unsigned LIMB_W    = 64;
  localparam int unsigned HALF_W    = LIMB_W / 2;
  localparam int unsigned SHAMT_W   = $clog2(LIMB_W);
  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned VERDICT_W = 2;

  // input tdata: action, limb_a, limb_b, scalar, padded to whole bytes
  localparam int unsigned IN_FIELDS_W = ACTION_W + 3 * LIMB_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  // output tdata: result_limb, running_out, verdict, divide_error
  localparam int unsigned OUT_FIELDS_W = 2 * LIMB_W + VERDICT_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_ADD = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_SUB = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_AND = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_OR  = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_XOR = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_NOT = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_MUL = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_DIV = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SHL = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_SHR = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_CMP = 4'd10;

  localparam logic [VERDICT_W-1:0] VERDICT_EQ = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_LT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_GT = 2'd2;

  // partial products of the shared 32x32 multiplier
  localparam logic [2:0] MUL_STEPS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* sv/multiword_limb_alu_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiword_limb_alu_unit
// limb-serial alu for multiword integers of 64-bit limbs, one limb per beat
// ----------------------------------------------------------------------------
// sequence: add, sub, logic, shifts, compare, spare codes and divide by zero go from
//   the exec state to the done state, then to the output register; mulword first
//   passes the mul state (four 32x32 partial products on one multiplier), divword
//   the div state (the low limb, after the running word if not below the divisor)
// one beat in flight; a stalled result waits in the fsm until the output register frees
// reset: rst_n synchronous active low, clears running word, verdict, fsm and output valid
module multiword_limb_alu_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // slave side: limb beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [3:0] action, [67:4] limb_a, [131:68] limb_b, [195:132] scalar, rest zero
  input  logic [mlalu_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] first_limb
  input  logic                          in_tuser,
  input  logic                          in_tlast,   // last_limb
  // master side: result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [63:0] result_limb, [127:64] running_out, [129:128] verdict,
  // [130] divide_error, rest zero
  output logic [mlalu_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast   // result_last
);

  import mlalu_pkg::*;

  // fsm
  state_t state_r, state_nxt;

  // latched input beat
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [LIMB_W-1:0]   a_r, a_nxt;
  logic [LIMB_W-1:0]   b_r, b_nxt;
  logic [LIMB_W-1:0]   sc_r, sc_nxt;
  logic                last_r, last_nxt;

  // architectural state carried from limb to limb
  logic [LIMB_W-1:0]    rw_r, rw_nxt;
  logic [VERDICT_W-1:0] verd_r, verd_nxt;

  // per-beat result
  logic [LIMB_W-1:0] res_r, res_nxt;
  logic              derr_r, derr_nxt;

  // shared step counter, multiplier and divider working registers
  logic [SHAMT_W-1:0]  cnt_r, cnt_nxt;
  logic [LIMB_W-1:0]   prod_r, prod_nxt;
  logic [2*LIMB_W-1:0] acc_r, acc_nxt;
  logic [LIMB_W-1:0]   rem_r, rem_nxt;
  logic [LIMB_W-1:0]   quo_r, quo_nxt;
  logic [LIMB_W-1:0]   dvd_r, dvd_nxt;
  logic                div_hi_r, div_hi_nxt;

  // output register
  logic                  ovalid_r, ovalid_nxt;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;

  logic in_acc, out_acc, slot_free;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = ovalid_r && out_tready;
  assign slot_free = !ovalid_r || out_tready;

  // --------------------------------------------------------------------------
  // combinational arithmetic
  // --------------------------------------------------------------------------
  logic [LIMB_W:0]     add_w, sub_w;
  logic [2*LIMB_W-1:0] shl_w, shr_w;
  logic [SHAMT_W-1:0]  shamt;

  assign shamt = sc_r[SHAMT_W-1:0];
  assign add_w = {1'b0, a_r} + {1'b0, b_r} + {{LIMB_W{1'b0}}, rw_r[0]};
  assign sub_w = {1'b0, a_r} - {1'b0, b_r} - {{LIMB_W{1'b0}}, rw_r[0]};
  // upper half of {a,prev} << s is (a << s) | (prev >> (64 - s)), no fill at zero
  assign shl_w = {a_r, rw_r} << shamt;
  assign shr_w = {rw_r, a_r} >> shamt;

  // --------------------------------------------------------------------------
  // shared 32x32 multiplier, one partial product per cycle
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0]   mul_x, mul_y;
  logic [LIMB_W-1:0]   mul_p;
  logic [2*LIMB_W-1:0] mul_add;

  // step 0: a0*s0, 1: a0*s1, 2: a1*s0, 3: a1*s1
  assign mul_x = cnt_r[1] ? a_r[LIMB_W-1:HALF_W]  : a_r[HALF_W-1:0];
  assign mul_y = cnt_r[0] ? sc_r[LIMB_W-1:HALF_W] : sc_r[HALF_W-1:0];
  assign mul_p = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

  // weight of the product registered in the previous step
  always_comb begin
    mul_add = {{LIMB_W{1'b0}}, prod_r};
    case (cnt_r[2:0])
      3'd1:    mul_add = {{LIMB_W{1'b0}}, prod_r};
      3'd2,
      3'd3:    mul_add = {{HALF_W{1'b0}}, prod_r, {HALF_W{1'b0}}};
      3'd4:    mul_add = {prod_r, {LIMB_W{1'b0}}};
      default: mul_add = {{LIMB_W{1'b0}}, prod_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // restoring divider step, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [LIMB_W:0]   div_r2, div_diff;
  logic              div_ge;
  logic [LIMB_W-1:0] div_rem;

  assign div_r2   = {rem_r, dvd_r[LIMB_W-1]};
  assign div_diff = div_r2 - {1'b0, sc_r};
  assign div_ge   = (div_r2 >= {1'b0, sc_r});
  assign div_rem  = div_ge ? div_diff[LIMB_W-1:0] : div_r2[LIMB_W-1:0];

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (act_r == ACT_MUL) begin
          state_nxt = ST_MUL;
        end else if (act_r == ACT_DIV && sc_r != '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        if (cnt_r[2:0] == MUL_STEPS) state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (cnt_r == '1 && !div_hi_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    act_nxt    = act_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    sc_nxt     = sc_r;
    last_nxt   = last_r;
    rw_nxt     = rw_r;
    verd_nxt   = verd_r;
    res_nxt    = res_r;
    derr_nxt   = derr_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvd_nxt    = dvd_r;
    div_hi_nxt = div_hi_r;
    ovalid_nxt = out_acc ? 1'b0 : ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_tdata[ACTION_W-1:0];
          a_nxt    = in_tdata[ACTION_W +: LIMB_W];
          b_nxt    = in_tdata[ACTION_W+LIMB_W +: LIMB_W];
          sc_nxt   = in_tdata[ACTION_W+2*LIMB_W +: LIMB_W];
          last_nxt = in_tlast;
          // first limb of a run starts from a clean running word and verdict
          if (in_tuser) begin
            rw_nxt   = '0;
            verd_nxt = VERDICT_EQ;
          end
        end
      end
      ST_EXEC: begin
        derr_nxt = 1'b0;
        res_nxt  = '0;
        case (act_r)
          ACT_ADD: begin
            res_nxt = add_w[LIMB_W-1:0];
            rw_nxt  = {{(LIMB_W-1){1'b0}}, add_w[LIMB_W]};
          end
          ACT_SUB: begin
            res_nxt = sub_w[LIMB_W-1:0];
            rw_nxt  = {{(LIMB_W-1){1'b0}}, sub_w[LIMB_W]};
          end
          ACT_AND: begin
            res_nxt = a_r & b_r;
            rw_nxt  = '0;
          end
          ACT_OR: begin
            res_nxt = a_r | b_r;
            rw_nxt  = '0;
          end
          ACT_XOR: begin
            res_nxt = a_r ^ b_r;
            rw_nxt  = '0;
          end
          ACT_NOT: begin
            res_nxt = ~a_r;
            rw_nxt  = '0;
          end
          ACT_MUL: begin
            // running word is the addend
            acc_nxt = {{LIMB_W{1'b0}}, rw_r};
            cnt_nxt = '0;
          end
          ACT_DIV: begin
            if (sc_r == '0) begin
              rw_nxt   = '0;
              derr_nxt = 1'b1;
            end else if (rw_r < sc_r) begin
              // usual case: remainder already below divisor, low limb only
              rem_nxt    = rw_r;
              dvd_nxt    = a_r;
              div_hi_nxt = 1'b0;
              cnt_nxt    = '0;
            end else begin
              // reduce the running word first, its quotient bits fall off
              rem_nxt    = '0;
              dvd_nxt    = rw_r;
              div_hi_nxt = 1'b1;
              cnt_nxt    = '0;
            end
          end
          ACT_SHL: begin
            res_nxt = shl_w[2*LIMB_W-1:LIMB_W];
            rw_nxt  = a_r;
          end
          ACT_SHR: begin
            res_nxt = shr_w[LIMB_W-1:0];
            rw_nxt  = a_r;
          end
          ACT_CMP: begin
            // first differing limb from the top decides, then it holds
            if (verd_r == VERDICT_EQ) begin
              if (a_r < b_r) begin
                verd_nxt = VERDICT_LT;
              end else if (a_r > b_r) begin
                verd_nxt = VERDICT_GT;
              end
            end
            rw_nxt = '0;
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      ST_MUL: begin
        if (cnt_r[2:0] != MUL_STEPS) prod_nxt = mul_p;
        if (cnt_r[2:0] != 3'd0) acc_nxt = acc_r + mul_add;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[2:0] == MUL_STEPS) begin
          res_nxt = acc_nxt[LIMB_W-1:0];
          rw_nxt  = acc_nxt[2*LIMB_W-1:LIMB_W];
        end
      end
      ST_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[LIMB_W-2:0], div_ge};
        dvd_nxt = {dvd_r[LIMB_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          if (div_hi_r) begin
            div_hi_nxt = 1'b0;
            dvd_nxt    = a_r;
          end else begin
            res_nxt = quo_nxt;
            rw_nxt  = div_rem;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = '0;
          odata_nxt[LIMB_W-1:0]             = res_r;
          odata_nxt[LIMB_W +: LIMB_W]       = rw_r;
          odata_nxt[2*LIMB_W +: VERDICT_W]  = verd_r;
          odata_nxt[2*LIMB_W+VERDICT_W]     = derr_r;
          olast_nxt  = last_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      rw_r     <= '0;
      verd_r   <= VERDICT_EQ;
      div_hi_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rw_r     <= rw_nxt;
      verd_r   <= verd_nxt;
      div_hi_r <= div_hi_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    sc_r    <= sc_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
    derr_r  <= derr_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvd_r   <= dvd_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

endmodule
